FILE: rtl/cdsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped disc span rasterizer package
// Shared constants, register indexes and the command and status types that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdsr_pkg;

   // Defaults for the top level parameters.
   localparam int MAX_RADIUS_DEF = 31;
   localparam int COORD_BITS_DEF = 11;

   // Fixed field widths.
   localparam int RADIUS_W = 5;
   localparam int ROW_W    = 6;
   localparam int LEN_W    = 6;
   localparam int CFG_W    = 8;

   // Internal arithmetic widths.
   localparam int DX_W  = 7;   // signed column or row offset from the disc center
   localparam int DSQ_W = 12;  // squared disc offsets and (2r+1) squared
   localparam int MAG_W = 8;   // magnitude of a doubled clip offset that can pass
   localparam int SQ_W  = 16;  // squares of clip offsets and of the clip diameter

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_CLIP_X    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_Y    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CLIP_DIAM = 2'd2;

   localparam logic [CFG_W-1:0] CLIP_X_RESET    = 8'd48;
   localparam logic [CFG_W-1:0] CLIP_Y_RESET    = 8'd109;
   localparam logic [CFG_W-1:0] CLIP_DIAM_RESET = 8'd96;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the disc word
      logic setup;   // per-disc constants
      logic lanes;   // per-column lane values
      logic issue;   // start one row into the row pipeline
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic advance;     // row pipeline moves this cycle
      logic row_last;    // the row counter sits on the final row
      logic pipe_empty;  // no row in flight ahead of the output register
   } status_type;

endpackage

FILE: rtl/clipped_disc_span_raster_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped disc span rasterizer
// Emits one horizontal span per row of a filled disc, clipped to a circle.
// ----------------------------------------------------------------------------
// Each accepted word (disc center and radius r, saturated to MAX_RADIUS) yields
// 2r+1 result words, one per row from the top of the disc down, each giving the
// row, the first visible column and the visible pixel count (zero, with a zero
// start column, for an empty row), the final row flagged. A disc passes through
// capture, per-disc setup, lane preparation and the issue of its 2r+1 rows,
// then a drain of the three-stage row pipeline (thresholds, lane compares, run
// encoding) into the output register and a return to idle, where the block
// takes the next disc while the last span still waits. A result stall freezes
// the whole row pipeline. The clip circle registers sit at byte addresses 0
// (center x), 4 (center y) and 8 (diameter); they may be written only while
// the block is idle.
module clipped_disc_span_raster_top #(
   parameter int MAX_RADIUS = cdsr_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = cdsr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_disc_x,
   input  logic signed [COORD_BITS-1:0]        req_disc_y,
   input  logic [cdsr_pkg::RADIUS_W-1:0]       req_disc_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_BITS:0]          rsp_row_y,
   output logic signed [COORD_BITS:0]          rsp_span_x,
   output logic [cdsr_pkg::LEN_W-1:0]          rsp_span_length,
   output logic                                rsp_last_row,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdsr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cdsr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cdsr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   cdsr_pkg::cmd_type           cmd;
   cdsr_pkg::status_type        status;
   logic [cdsr_pkg::CFG_W-1:0]  clip_x, clip_y, clip_diam;

   // Clip region registers.
   cdsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .clip_x      (clip_x),
      .clip_y      (clip_y),
      .clip_diam   (clip_diam)
   );

   // Sequencer.
   cdsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Lanes, row pipeline and output register.
   cdsr_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_disc_x      (req_disc_x),
      .req_disc_y      (req_disc_y),
      .req_disc_radius (req_disc_radius),
      .clip_x          (clip_x),
      .clip_y          (clip_y),
      .clip_diam       (clip_diam),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_y       (rsp_row_y),
      .rsp_span_x      (rsp_span_x),
      .rsp_span_length (rsp_span_length),
      .rsp_last_row    (rsp_last_row)
   );

endmodule

FILE: rtl/cdsr_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clip region registers
// APB-style register file holding the clip circle center and diameter.
// ----------------------------------------------------------------------------
module cdsr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cdsr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [cdsr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [cdsr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   output logic [cdsr_pkg::CFG_W-1:0]            clip_x,
   output logic [cdsr_pkg::CFG_W-1:0]            clip_y,
   output logic [cdsr_pkg::CFG_W-1:0]            clip_diam
);

   logic [cdsr_pkg::CFG_W-1:0]     clip_x_ff, clip_x_in;
   logic [cdsr_pkg::CFG_W-1:0]     clip_y_ff, clip_y_in;
   logic [cdsr_pkg::CFG_W-1:0]     clip_diam_ff, clip_diam_in;
   logic [cdsr_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[cdsr_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      clip_x_in    = clip_x_ff;
      clip_y_in    = clip_y_ff;
      clip_diam_in = clip_diam_ff;
      if (wr_en) begin
         case (reg_idx)
            cdsr_pkg::REG_CLIP_X:    clip_x_in    = csr_pwdata[cdsr_pkg::CFG_W-1:0];
            cdsr_pkg::REG_CLIP_Y:    clip_y_in    = csr_pwdata[cdsr_pkg::CFG_W-1:0];
            cdsr_pkg::REG_CLIP_DIAM: clip_diam_in = csr_pwdata[cdsr_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_ff    <= cdsr_pkg::CLIP_X_RESET;
         clip_y_ff    <= cdsr_pkg::CLIP_Y_RESET;
         clip_diam_ff <= cdsr_pkg::CLIP_DIAM_RESET;
      end else begin
         clip_x_ff    <= clip_x_in;
         clip_y_ff    <= clip_y_in;
         clip_diam_ff <= clip_diam_in;
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         cdsr_pkg::REG_CLIP_X:    csr_prdata = cdsr_pkg::CSR_DATA_W'(clip_x_ff);
         cdsr_pkg::REG_CLIP_Y:    csr_prdata = cdsr_pkg::CSR_DATA_W'(clip_y_ff);
         cdsr_pkg::REG_CLIP_DIAM: csr_prdata = cdsr_pkg::CSR_DATA_W'(clip_diam_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign clip_x    = clip_x_ff;
   assign clip_y    = clip_y_ff;
   assign clip_diam = clip_diam_ff;

endmodule

FILE: rtl/cdsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rasterizer controller
// Sequences one disc: capture, setup, lane preparation, row issue and drain.
// ----------------------------------------------------------------------------
module cdsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output cdsr_pkg::cmd_type      cmd,
   input  cdsr_pkg::status_type   status
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SETUP = 5'b00010,
      ST_LANES = 5'b00100,
      ST_ROWS  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_LANES;
         end
         ST_LANES: begin
            cmd.lanes = 1'b1;
            state_in  = ST_ROWS;
         end
         ST_ROWS: begin
            if (status.advance) begin
               cmd.issue = 1'b1;
               if (status.row_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // Wait until every row has reached the output register.
            if (status.pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new disc may only overwrite the datapath once no row is in flight.
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> status.pipe_empty)
      else $error("Controller idle while rows are still in the pipeline.");

endmodule

FILE: rtl/cdsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rasterizer datapath
// Disc capture, per-column lanes, a three-stage row pipeline and the output
// register.
// ----------------------------------------------------------------------------
module cdsr_datapath #(
   parameter int MAX_RADIUS = cdsr_pkg::MAX_RADIUS_DEF,
   parameter int COORD_BITS = cdsr_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdsr_pkg::cmd_type                   cmd,
   output cdsr_pkg::status_type                status,
   input  logic signed [COORD_BITS-1:0]        req_disc_x,
   input  logic signed [COORD_BITS-1:0]        req_disc_y,
   input  logic [cdsr_pkg::RADIUS_W-1:0]       req_disc_radius,
   input  logic [cdsr_pkg::CFG_W-1:0]          clip_x,
   input  logic [cdsr_pkg::CFG_W-1:0]          clip_y,
   input  logic [cdsr_pkg::CFG_W-1:0]          clip_diam,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_BITS:0]          rsp_row_y,
   output logic signed [COORD_BITS:0]          rsp_span_x,
   output logic [cdsr_pkg::LEN_W-1:0]          rsp_span_length,
   output logic                                rsp_last_row
);

   localparam int NUM_LANES = 2 * MAX_RADIUS + 1;
   localparam int LANE_W    = $clog2(NUM_LANES);
   localparam int Y_W       = COORD_BITS + 1;   // pixel coordinates in the disc
   localparam int D_W       = COORD_BITS + 3;   // doubled offsets to the clip center
   localparam int L_W       = COORD_BITS + 4;   // doubled lane offsets
   localparam int RW        = cdsr_pkg::RADIUS_W;
   localparam int DSQ_W     = cdsr_pkg::DSQ_W;
   localparam int SQ_W      = cdsr_pkg::SQ_W;
   localparam int MAG_W     = cdsr_pkg::MAG_W;
   localparam int DX_W      = cdsr_pkg::DX_W;
   localparam int ROW_W     = cdsr_pkg::ROW_W;
   localparam int LEN_W     = cdsr_pkg::LEN_W;
   localparam logic signed [L_W-1:0] LANE_LIM = L_W'((1 << MAG_W) - 1);
   localparam logic signed [D_W-1:0] ROW_LIM  = D_W'((1 << MAG_W) - 1);

   // Captured disc.
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [RW-1:0]                rad_ff, rad_sat;

   // Per-disc constants.
   logic signed [Y_W-1:0]        base_x_ff, base_x_in;
   logic signed [D_W-1:0]        bx_ff, bx_in;
   logic [DSQ_W-1:0]             dd2_ff, dd2_in;
   logic [SQ_W-1:0]              d2_ff, d2_in;
   logic [RW:0]                  dd;
   logic [ROW_W-1:0]             row_cnt_ff, row_cnt_in;

   // Lane registers, one per column of the bounding box of a disc of MAX_RADIUS.
   logic [SQ_W-1:0]              lane_sq_ff  [NUM_LANES];
   logic [DSQ_W-1:0]             lane_dsq_ff [NUM_LANES];
   logic [NUM_LANES-1:0]         lane_near_ff;

   // Stage A: row thresholds.
   logic                         a_valid_ff;
   logic                         a_last_ff;
   logic signed [Y_W-1:0]        a_y_ff, a_y_in;
   logic [DSQ_W-1:0]             a_u_ff, a_u_in;
   logic [SQ_W-1:0]              a_t_ff;
   logic                         a_ok_ff, a_ok_in;
   logic signed [DX_W-1:0]       dy;
   logic [DSQ_W-1:0]             dysq;
   logic signed [D_W-1:0]        dy2;
   logic                         near_y;
   logic [MAG_W-1:0]             mag_y;
   logic [SQ_W-1:0]              ysq;
   logic [SQ_W:0]                t_full;

   // Stage B: visibility mask.
   logic                         b_valid_ff;
   logic                         b_last_ff;
   logic signed [Y_W-1:0]        b_y_ff;
   logic [NUM_LANES-1:0]         b_mask_ff, mask_in;

   // Stage C: first and last visible lanes.
   logic                         c_valid_ff;
   logic                         c_last_ff;
   logic signed [Y_W-1:0]        c_y_ff;
   logic                         c_any_ff;
   logic [LANE_W-1:0]            c_lo_ff, c_hi_ff, lo_idx, hi_idx, rev_idx;
   logic [NUM_LANES-1:0]         mask_rev, lo_oh, rev_oh;

   // Output register.
   logic                         rsp_valid_ff;
   logic signed [Y_W-1:0]        rsp_row_y_ff, rsp_span_x_ff, span_x_in;
   logic [LEN_W-1:0]             rsp_span_length_ff, span_len_in;
   logic                         rsp_last_row_ff;
   logic                         advance;

   assign advance = !rsp_valid_ff || rsp_ready;

   assign status.advance    = advance;
   assign status.row_last   = (row_cnt_ff == ROW_W'({rad_ff, 1'b0}));
   assign status.pipe_empty = !a_valid_ff && !b_valid_ff && !c_valid_ff;

   // Disc capture with the radius saturated to MAX_RADIUS.
   assign rad_sat = (req_disc_radius > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : req_disc_radius;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff  <= req_disc_x;
         cy_ff  <= req_disc_y;
         rad_ff <= rad_sat;
      end
   end

   // Per-disc constants: left column, its doubled clip offset and squared diameters.
   assign dd        = {rad_ff, 1'b1};
   assign base_x_in = Y_W'(cx_ff) - Y_W'(rad_ff);
   assign bx_in     = ((D_W'(cx_ff) - D_W'(rad_ff) - D_W'(clip_x)) <<< 1) + D_W'(1);
   assign dd2_in    = DSQ_W'(dd) * DSQ_W'(dd);
   assign d2_in     = SQ_W'(clip_diam) * SQ_W'(clip_diam);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         base_x_ff <= base_x_in;
         bx_ff     <= bx_in;
         dd2_ff    <= dd2_in;
         d2_ff     <= d2_in;
      end
   end

   // Row counter.
   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (cmd.setup) begin
         row_cnt_in = '0;
      end else if (cmd.issue) begin
         row_cnt_in = row_cnt_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Lanes: each column keeps its squared disc offset and squared clip offset.
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      logic signed [L_W-1:0]  dx2;
      logic signed [DX_W-1:0] dx;
      logic [MAG_W-1:0]       mag;
      logic                   near;

      assign dx2  = L_W'(bx_ff) + L_W'(2 * k);
      assign near = (dx2 <= LANE_LIM) && (dx2 >= -LANE_LIM);
      assign mag  = dx2[L_W-1] ? MAG_W'(-dx2) : MAG_W'(dx2);
      assign dx   = DX_W'(k) - DX_W'(rad_ff);

      always_ff @(posedge clock) begin
         if (cmd.lanes) begin
            lane_sq_ff[k]   <= SQ_W'(mag) * SQ_W'(mag);
            lane_dsq_ff[k]  <= DSQ_W'(dx) * DSQ_W'(dx);
            lane_near_ff[k] <= near;
         end
      end
   end

   // Stage A: disc and clip thresholds of the issued row.
   always_comb begin
      a_y_in = Y_W'(cy_ff) - Y_W'(rad_ff) + Y_W'(row_cnt_ff);
      dy     = DX_W'(row_cnt_ff) - DX_W'(rad_ff);
      dysq   = DSQ_W'(dy) * DSQ_W'(dy);
      a_u_in = dd2_ff - (dysq << 2);
      dy2    = (D_W'(a_y_in) <<< 1) + D_W'(1) - (D_W'(clip_y) << 1);
      near_y = (dy2 <= ROW_LIM) && (dy2 >= -ROW_LIM);
      mag_y  = dy2[D_W-1] ? MAG_W'(-dy2) : MAG_W'(dy2);
      ysq    = SQ_W'(mag_y) * SQ_W'(mag_y);
      t_full = {1'b0, d2_ff} - {1'b0, ysq};
      a_ok_in = near_y && !t_full[SQ_W];
   end

   // Stage B: a pixel shows when it lies in both circles.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         mask_in[k] = a_ok_ff && lane_near_ff[k] && (lane_sq_ff[k] <= a_t_ff) &&
                      ({lane_dsq_ff[k], 2'b00} <= {2'b00, a_u_ff});
      end
   end

   // Stage C: isolate the lowest set lane and the highest one (through the
   // reversed mask) and encode both.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         mask_rev[k] = b_mask_ff[NUM_LANES-1-k];
      end
      lo_oh   = b_mask_ff & (~b_mask_ff + NUM_LANES'(1));
      rev_oh  = mask_rev & (~mask_rev + NUM_LANES'(1));
      lo_idx  = '0;
      rev_idx = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (lo_oh[k]) begin
            lo_idx = lo_idx | LANE_W'(k);
         end
         if (rev_oh[k]) begin
            rev_idx = rev_idx | LANE_W'(k);
         end
      end
      hi_idx = LANE_W'(NUM_LANES - 1) - rev_idx;
   end

   // Output word.
   assign span_len_in = c_any_ff ? (LEN_W'(c_hi_ff) - LEN_W'(c_lo_ff) + LEN_W'(1)) : '0;
   assign span_x_in   = c_any_ff ? (base_x_ff + Y_W'(c_lo_ff)) : '0;

   // Pipeline valid bits; the whole pipeline moves when the output register frees.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= cmd.issue;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_last_ff          <= status.row_last;
         a_y_ff             <= a_y_in;
         a_u_ff             <= a_u_in;
         a_t_ff             <= t_full[SQ_W-1:0];
         a_ok_ff            <= a_ok_in;
         b_last_ff          <= a_last_ff;
         b_y_ff             <= a_y_ff;
         b_mask_ff          <= mask_in;
         c_last_ff          <= b_last_ff;
         c_y_ff             <= b_y_ff;
         c_any_ff           <= |b_mask_ff;
         c_lo_ff            <= lo_idx;
         c_hi_ff            <= hi_idx;
         rsp_row_y_ff       <= c_y_ff;
         rsp_span_x_ff      <= span_x_in;
         rsp_span_length_ff <= span_len_in;
         rsp_last_row_ff    <= c_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_y       = rsp_row_y_ff;
   assign rsp_span_x      = rsp_span_x_ff;
   assign rsp_span_length = rsp_span_length_ff;
   assign rsp_last_row    = rsp_last_row_ff;

   // The visible run of a row is one interval, so its ends are ordered.
   a_run_ordered: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && c_any_ff |-> c_lo_ff <= c_hi_ff)
      else $error("Last visible lane lies before the first one.");

   // An empty row reports a zero start column.
   a_empty_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_span_length_ff == '0 |-> rsp_span_x_ff == '0)
      else $error("Empty row carries a nonzero start column.");

   // Rows are issued only within the disc.
   a_row_in_disc: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> row_cnt_ff <= ROW_W'({rad_ff, 1'b0}))
      else $error("Row issued beyond the bottom of the disc.");

endmodule
